// ----- rtl/core/gscd_pkg.sv -----
package gscd_pkg;

  localparam int ANGLE_W    = 8;
  localparam int DUTY_W     = 8;
  localparam int SCALE_W    = 5;
  localparam int MODE_W     = 2;
  localparam int NUM_PHASES = 3;
  localparam int SCALE_SHIFT = 4;
  localparam int PROD_W     = DUTY_W + SCALE_W;

  localparam int SWEEP_DIVIDER_DEF = 4;
  localparam int SWEEP_LIMIT_DEF   = 255;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ROLL_WR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PITCH_WR = 2'd2;

  // Register indexes on the configuration port
  localparam logic REG_ROLL_FROZEN  = 1'b0;
  localparam logic REG_PITCH_FROZEN = 1'b1;

  // Table offsets of phases A, B and C
  localparam logic [NUM_PHASES-1:0][ANGLE_W-1:0] PHASE_OFFSET = {8'd170, 8'd85, 8'd0};

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ANGLE_W-1:0] table_index;
    logic [DUTY_W-1:0]  table_value;
    logic [ANGLE_W-1:0] roll_angle;
    logic [ANGLE_W-1:0] pitch_angle;
    logic [SCALE_W-1:0] soft_start;
    logic               pids_drive;
    logic               frozen;
    logic               motor_test;
    logic               sweep_start;
    logic               sweep_on_pitch;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  roll_phase_a;
    logic [DUTY_W-1:0]  roll_phase_b;
    logic [DUTY_W-1:0]  roll_phase_c;
    logic [DUTY_W-1:0]  pitch_phase_a;
    logic [DUTY_W-1:0]  pitch_phase_b;
    logic [DUTY_W-1:0]  pitch_phase_c;
    logic               sweep_active;
    logic [ANGLE_W-1:0] sweep_angle;
  } out_item_t;

  // Per-item drive decision handed from angle selection to the scaling stage
  typedef struct packed {
    logic               drive_roll;
    logic               drive_pitch;
    logic               sweep_active;
    logic [ANGLE_W-1:0] sweep_angle;
  } drive_t;

endpackage

// ----- rtl/core/gscd_ram.sv -----
module gscd_ram
  import gscd_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [ANGLE_W-1:0] waddr,
  input  logic [DUTY_W-1:0]  wdata,
  input  logic               re,
  input  logic [ANGLE_W-1:0] raddr,
  output logic [DUTY_W-1:0]  rdata
);

  logic [DUTY_W-1:0] mem [2**ANGLE_W];
  logic [DUTY_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/gscd_scale.sv -----
module gscd_scale
  import gscd_pkg::*;
(
  input  logic [DUTY_W-1:0]  entry,
  input  logic [SCALE_W-1:0] scale,
  output logic [DUTY_W-1:0]  duty
);

  logic [PROD_W-1:0]                 prod;
  logic [PROD_W-SCALE_SHIFT-1:0]     shifted;

  // Scale in sixteenths, saturate to full duty
  assign prod    = PROD_W'(entry) * PROD_W'(scale);
  assign shifted = prod[PROD_W-1:SCALE_SHIFT];
  assign duty    = (shifted > (PROD_W-SCALE_SHIFT)'({DUTY_W{1'b1}})) ?
                   {DUTY_W{1'b1}} : shifted[DUTY_W-1:0];

endmodule

// ----- rtl/core/gscd_drive_sel.sv -----
module gscd_drive_sel
  import gscd_pkg::*;
#(
  parameter int SWEEP_DIVIDER = SWEEP_DIVIDER_DEF,
  parameter int SWEEP_LIMIT   = SWEEP_LIMIT_DEF
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  in_item_t           item,
  input  logic [ANGLE_W-1:0] roll_frozen,
  input  logic [ANGLE_W-1:0] pitch_frozen,
  output logic [ANGLE_W-1:0] roll_angle,
  output logic [ANGLE_W-1:0] pitch_angle,
  output drive_t             drive
);

  localparam logic [ANGLE_W-1:0] DIV_LOAD  = ANGLE_W'(SWEEP_DIVIDER);
  localparam logic [ANGLE_W-1:0] POS_LIMIT = ANGLE_W'(SWEEP_LIMIT);

  logic               running_r, running_nxt;
  logic               axis_r, axis_nxt;
  logic [ANGLE_W-1:0] pos_r, pos_nxt;
  logic [ANGLE_W-1:0] cnt_r, cnt_nxt;
  logic [ANGLE_W-1:0] test_r, test_nxt;

  // Pick the drive source by priority and advance the sweep and test angle
  always_comb begin
    running_nxt = running_r;
    axis_nxt    = axis_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    test_nxt    = test_r;
    roll_angle  = item.roll_angle;
    pitch_angle = item.pitch_angle;
    drive.drive_roll  = 1'b0;
    drive.drive_pitch = 1'b0;
    if (item.mode == MODE_TICK) begin
      if (item.sweep_start) begin
        running_nxt = 1'b1;
        axis_nxt    = item.sweep_on_pitch;
        pos_nxt     = '0;
        cnt_nxt     = DIV_LOAD;
      end
      if (item.pids_drive) begin
        drive.drive_roll  = 1'b1;
        drive.drive_pitch = 1'b1;
      end else if (running_nxt) begin
        if (cnt_nxt == '0) begin
          cnt_nxt = DIV_LOAD;
          if (pos_nxt < POS_LIMIT) begin
            pos_nxt = pos_nxt + 1'b1;
          end else begin
            running_nxt = 1'b0;
          end
        end
        cnt_nxt     = cnt_nxt - 1'b1;
        roll_angle  = pos_nxt;
        pitch_angle = pos_nxt;
        drive.drive_roll  = !axis_nxt;
        drive.drive_pitch = axis_nxt;
      end else if (item.frozen) begin
        roll_angle  = roll_frozen;
        pitch_angle = pitch_frozen;
        drive.drive_roll  = 1'b1;
        drive.drive_pitch = 1'b1;
      end else if (item.motor_test) begin
        roll_angle  = test_r;
        pitch_angle = test_r;
        test_nxt    = test_r + 1'b1;
        drive.drive_roll  = 1'b1;
        drive.drive_pitch = 1'b1;
      end
    end
    drive.sweep_active = running_nxt;
    drive.sweep_angle  = pos_nxt;
  end

  // Commit state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      axis_r    <= 1'b0;
      pos_r     <= '0;
      cnt_r     <= '0;
      test_r    <= '0;
    end else if (step) begin
      running_r <= running_nxt;
      axis_r    <= axis_nxt;
      pos_r     <= pos_nxt;
      cnt_r     <= cnt_nxt;
      test_r    <= test_nxt;
    end
  end

endmodule

// ----- rtl/core/gimbal_sine_commutation_drive_core.sv -----
// Sine commutation drive for two three-phase gimbal motors. Each accepted
// transaction is either a tick, which picks a drive angle per motor (controller
// angles, then the autosetup sweep, then the frozen angles, then the test
// angle) and produces three scaled PWM duties per driven motor, or a write of
// one sine table entry; the unused mode changes nothing. One transaction is
// accepted per cycle unless the output side stalls; its result passes first
// through the registered table reads (each phase of each motor has its own
// copy of the table so all six reads happen together) and then through the
// scale and saturate into the output register. The sine tables hold no reset
// value and must be loaded before a tick reads them; frozen angles are set
// through the APB registers at 0x0 (roll) and 0x4 (pitch).
module gimbal_sine_commutation_drive_core
  import gscd_pkg::*;
#(
  parameter int SWEEP_DIVIDER = SWEEP_DIVIDER_DEF,
  parameter int SWEEP_LIMIT   = SWEEP_LIMIT_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               in_accept;
  logic               s1_adv;
  logic               s1_valid_r, s1_valid_nxt;
  drive_t             s1_drive_r;
  logic [SCALE_W-1:0] s1_scale_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic [ANGLE_W-1:0] roll_frozen_r, pitch_frozen_r;
  logic [ANGLE_W-1:0] roll_angle, pitch_angle;
  drive_t             drive;

  logic [NUM_PHASES-1:0][DUTY_W-1:0] roll_rd, pitch_rd;
  logic [NUM_PHASES-1:0][DUTY_W-1:0] roll_duty, pitch_duty;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_frozen_r  <= '0;
      pitch_frozen_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_ROLL_FROZEN:  roll_frozen_r  <= pwdata[ANGLE_W-1:0];
        REG_PITCH_FROZEN: pitch_frozen_r <= pwdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROLL_FROZEN:  prdata = 32'(roll_frozen_r);
      REG_PITCH_FROZEN: prdata = 32'(pitch_frozen_r);
      default:          prdata = '0;
    endcase
  end

  // Handshake: stage one advances whenever the output register frees up
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_accept = in_valid && in_ready;

  gscd_drive_sel #(
    .SWEEP_DIVIDER (SWEEP_DIVIDER),
    .SWEEP_LIMIT   (SWEEP_LIMIT)
  ) u_drive_sel (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_accept),
    .item         (in_data),
    .roll_frozen  (roll_frozen_r),
    .pitch_frozen (pitch_frozen_r),
    .roll_angle   (roll_angle),
    .pitch_angle  (pitch_angle),
    .drive        (drive)
  );

  // One table copy per phase per motor, read at the phase-shifted angle
  for (genvar p = 0; p < NUM_PHASES; p++) begin : g_phase
    gscd_ram u_roll_ram (
      .clk   (clk),
      .we    (in_accept && (in_data.mode == MODE_ROLL_WR)),
      .waddr (in_data.table_index),
      .wdata (in_data.table_value),
      .re    (in_accept),
      .raddr (roll_angle + PHASE_OFFSET[p]),
      .rdata (roll_rd[p])
    );

    gscd_ram u_pitch_ram (
      .clk   (clk),
      .we    (in_accept && (in_data.mode == MODE_PITCH_WR)),
      .waddr (in_data.table_index),
      .wdata (in_data.table_value),
      .re    (in_accept),
      .raddr (pitch_angle + PHASE_OFFSET[p]),
      .rdata (pitch_rd[p])
    );

    gscd_scale u_roll_scale (
      .entry (roll_rd[p]),
      .scale (s1_scale_r),
      .duty  (roll_duty[p])
    );

    gscd_scale u_pitch_scale (
      .entry (pitch_rd[p]),
      .scale (s1_scale_r),
      .duty  (pitch_duty[p])
    );
  end

  // Stage one control
  assign s1_valid_nxt = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_drive_r <= drive;
      s1_scale_r <= in_data.soft_start;
    end
  end

  // Output register doubles as the held duty state
  always_comb begin
    out_data_nxt = out_data_r;
    if (s1_drive_r.drive_roll) begin
      out_data_nxt.roll_phase_a = roll_duty[0];
      out_data_nxt.roll_phase_b = roll_duty[1];
      out_data_nxt.roll_phase_c = roll_duty[2];
    end
    if (s1_drive_r.drive_pitch) begin
      out_data_nxt.pitch_phase_a = pitch_duty[0];
      out_data_nxt.pitch_phase_b = pitch_duty[1];
      out_data_nxt.pitch_phase_c = pitch_duty[2];
    end
    out_data_nxt.sweep_active = s1_drive_r.sweep_active;
    out_data_nxt.sweep_angle  = s1_drive_r.sweep_angle;
  end

  assign out_valid_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        out_data_r <= out_data_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/gscd_checker.sv -----
module gscd_checker
  import gscd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Drop results during reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Keep input open while the output side drains
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input blocked while output ready");

  // Advance results: a transaction accepted into an empty block passes on to the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid && out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after accepted transaction");

endmodule

bind gimbal_sine_commutation_drive_core gscd_checker u_gscd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/sv/gimbal_sine_commutation_drive_core_test.sv -----
`timescale 1ns / 1ps

module gimbal_sine_commutation_drive_core_test;
  import gscd_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [ANGLE_W-1:0] PH_B_SHIFT = 8'd85;
  localparam logic [ANGLE_W-1:0] PH_C_SHIFT = 8'd170;
  localparam int PHASE_ITEMS = 150;
  localparam int HOLD_CYCLES = 100;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [NUM_PHASES-1:0][DUTY_W-1:0] duty3_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Shadow state of the commutation drive
  logic [DUTY_W-1:0] roll_tab [256];
  logic [DUTY_W-1:0] pitch_tab [256];
  duty3_t roll_duty = '0;
  duty3_t pitch_duty = '0;
  logic [ANGLE_W-1:0] test_ang = '0;
  logic sw_run = 1'b0;
  logic sw_axis = 1'b0;
  logic [ANGLE_W-1:0] sw_pos = '0;
  logic [7:0] sw_cnt = '0;
  logic [ANGLE_W-1:0] roll_frz = '0;
  logic [ANGLE_W-1:0] pitch_frz = '0;

  in_item_t pending_items [$];
  out_item_t expected_duties [$];
  int mismatches = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  bit hold_arm = 1'b0;
  bit hold_done = 1'b0;

  gimbal_sine_commutation_drive_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Look up three phases of one motor and scale by soft start, saturating
  function automatic duty3_t phase_duties(input logic on_pitch, input logic [ANGLE_W-1:0] ang,
                                          input logic [SCALE_W-1:0] scale);
    duty3_t d;
    logic [ANGLE_W-1:0] idx;
    logic [DUTY_W-1:0] entry;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] shifted;
    for (int p = 0; p < NUM_PHASES; p++) begin
      idx = ang + ((p == 0) ? 8'd0 : (p == 1) ? PH_B_SHIFT : PH_C_SHIFT);
      entry = on_pitch ? pitch_tab[idx] : roll_tab[idx];
      prod = PROD_W'(entry) * PROD_W'(scale);
      shifted = prod >> SCALE_SHIFT;
      d[p] = (shifted > 255) ? 8'hFF : shifted[DUTY_W-1:0];
    end
    return d;
  endfunction

  // Advance the shadow state by one transaction and queue the held duties
  task automatic commutate(input in_item_t it);
    out_item_t r;
    case (it.mode)
      MODE_ROLL_WR: roll_tab[it.table_index] = it.table_value;
      MODE_PITCH_WR: pitch_tab[it.table_index] = it.table_value;
      MODE_TICK: begin
        if (it.sweep_start) begin
          sw_run = 1'b1;
          sw_axis = it.sweep_on_pitch;
          sw_pos = '0;
          sw_cnt = 8'(SWEEP_DIVIDER_DEF);
        end
        if (it.pids_drive) begin
          roll_duty = phase_duties(1'b0, it.roll_angle, it.soft_start);
          pitch_duty = phase_duties(1'b1, it.pitch_angle, it.soft_start);
        end else if (sw_run) begin
          if (sw_cnt == 0) begin
            sw_cnt = 8'(SWEEP_DIVIDER_DEF);
            if (int'(sw_pos) < SWEEP_LIMIT_DEF) sw_pos = sw_pos + 1'b1;
            else sw_run = 1'b0;
          end
          if (sw_axis) pitch_duty = phase_duties(1'b1, sw_pos, it.soft_start);
          else roll_duty = phase_duties(1'b0, sw_pos, it.soft_start);
          sw_cnt = sw_cnt - 1'b1;
        end else if (it.frozen) begin
          pitch_duty = phase_duties(1'b1, pitch_frz, it.soft_start);
          roll_duty = phase_duties(1'b0, roll_frz, it.soft_start);
        end else if (it.motor_test) begin
          roll_duty = phase_duties(1'b0, test_ang, it.soft_start);
          pitch_duty = phase_duties(1'b1, test_ang, it.soft_start);
          test_ang = test_ang + 1'b1;
        end
      end
      default: ;
    endcase
    r.roll_phase_a = roll_duty[0];
    r.roll_phase_b = roll_duty[1];
    r.roll_phase_c = roll_duty[2];
    r.pitch_phase_a = pitch_duty[0];
    r.pitch_phase_b = pitch_duty[1];
    r.pitch_phase_c = pitch_duty[2];
    r.sweep_active = sw_run;
    r.sweep_angle = sw_pos;
    expected_duties.push_back(r);
  endtask

  // Driver: predict on each accepted transaction, then offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) commutate(in_data);
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Monitor: compare each result against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_duties.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %h", out_data);
      end else begin
        want = expected_duties.pop_front();
        check_field("roll_phase_a", want.roll_phase_a, out_data.roll_phase_a);
        check_field("roll_phase_b", want.roll_phase_b, out_data.roll_phase_b);
        check_field("roll_phase_c", want.roll_phase_c, out_data.roll_phase_c);
        check_field("pitch_phase_a", want.pitch_phase_a, out_data.pitch_phase_a);
        check_field("pitch_phase_b", want.pitch_phase_b, out_data.pitch_phase_b);
        check_field("pitch_phase_c", want.pitch_phase_c, out_data.pitch_phase_c);
        check_field("sweep_active", 8'(want.sweep_active), 8'(out_data.sweep_active));
        check_field("sweep_angle", want.sweep_angle, out_data.sweep_angle);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("gimbal_sine_commutation_drive_core_test: FAIL");
      $finish;
    end
  end

  function automatic in_item_t raw_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    if ($urandom_range(4) == 0) return SCALE_W'($urandom_range(31));
    return SCALE_W'($urandom_range(16));
  endfunction

  function automatic in_item_t mk_tick(input logic pids, input logic frz, input logic mtest,
                                       input logic sstart, input logic son_pitch,
                                       input logic [7:0] ra, input logic [7:0] pa,
                                       input logic [SCALE_W-1:0] scale);
    in_item_t it;
    it = raw_item();
    it.mode = MODE_TICK;
    it.pids_drive = pids;
    it.frozen = frz;
    it.motor_test = mtest;
    it.sweep_start = sstart;
    it.sweep_on_pitch = son_pitch;
    it.roll_angle = ra;
    it.pitch_angle = pa;
    it.soft_start = scale;
    return it;
  endfunction

  function automatic in_item_t mk_write(input logic [MODE_W-1:0] mode, input logic [7:0] idx,
                                        input logic [7:0] val);
    in_item_t it;
    it = raw_item();
    it.mode = mode;
    it.table_index = idx;
    it.table_value = val;
    return it;
  endfunction

  function automatic in_item_t rand_tick();
    in_item_t it;
    it = raw_item();
    it.mode = MODE_TICK;
    it.soft_start = pick_scale();
    it.sweep_start = ($urandom_range(11) == 0);
    it.pids_drive = ($urandom_range(2) == 0);
    return it;
  endfunction

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_ROLL_FROZEN) roll_frz = val;
    else pitch_frz = val;
  endtask

  task automatic wait_drain();
    while (pending_items.size() != 0 || in_valid || expected_duties.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random mix of table updates, sweeps, controller ticks, test spins and noise
  task automatic add_random(input int count);
    int added;
    int len;
    in_item_t it;
    added = 0;
    while (added < count) begin
      case ($urandom_range(9))
        0, 1: begin
          len = $urandom_range(1, 6);
          repeat (len) pending_items.push_back(mk_write($urandom_range(1) ? MODE_PITCH_WR
                                                        : MODE_ROLL_WR, 8'($urandom),
                                                        8'($urandom)));
        end
        2, 3, 4: begin
          len = $urandom_range(4, 40);
          it = rand_tick();
          it.pids_drive = 1'b0;
          it.sweep_start = 1'b1;
          pending_items.push_back(it);
          repeat (len) begin
            it = rand_tick();
            it.sweep_start = 1'b0;
            it.pids_drive = ($urandom_range(9) == 0);
            if ($urandom_range(15) == 0) it.mode = MODE_ROLL_WR;
            pending_items.push_back(it);
          end
          len++;
        end
        5, 6, 7: begin
          len = $urandom_range(1, 10);
          repeat (len) pending_items.push_back(rand_tick());
        end
        8: begin
          len = $urandom_range(5, 30);
          repeat (len) pending_items.push_back(mk_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                                                       8'($urandom), 8'($urandom), pick_scale()));
        end
        default: begin
          len = 1;
          it = raw_item();
          if ($urandom_range(1)) it.mode = MODE_UNUSED;
          pending_items.push_back(it);
        end
      endcase
      added += len;
    end
  endtask

  task automatic add_directed();
    // full-scale and zero entries at the phase offsets of angles 0 and 255
    pending_items.push_back(mk_write(MODE_ROLL_WR, 8'd0, 8'd255));
    pending_items.push_back(mk_write(MODE_ROLL_WR, 8'd85, 8'd0));
    pending_items.push_back(mk_write(MODE_PITCH_WR, 8'd255, 8'd255));
    pending_items.push_back(mk_write(MODE_PITCH_WR, 8'd169, 8'd0));
    pending_items.push_back(mk_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd255, 5'd16));
    pending_items.push_back(mk_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd255, 8'd0, 5'd0));
    pending_items.push_back(mk_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd255, 5'd31));
    pending_items.push_back(mk_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd128, 8'd64, 5'd17));
    // unused mode leaves everything held
    pending_items.push_back(mk_write(MODE_UNUSED, 8'd0, 8'd0));
    pending_items.push_back(mk_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 5'd16));
    pending_items.push_back(mk_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 5'd16));
    pending_items.push_back(mk_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 5'd8));
    pending_items.push_back(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 5'd16));
    // sweep started while the controller drives, then stepped by the sweep
    pending_items.push_back(mk_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'd10, 8'd20, 5'd16));
    repeat (6) pending_items.push_back(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                               8'd0, 8'd0, 5'd16));
    // restart on roll; the sweep outranks frozen and test
    pending_items.push_back(mk_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'd0, 8'd0, 5'd16));
    pending_items.push_back(mk_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 5'd12));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 24 : (ph == 1) ? 68 : 0;
      recv_idle = (ph == 0) ? 68 : (ph == 1) ? 24 : 0;
      write_reg(REG_ROLL_FROZEN, (ph == 0) ? 8'd0 : (ph == 1) ? 8'd255 : 8'($urandom));
      write_reg(REG_PITCH_FROZEN, (ph == 0) ? 8'd255 : (ph == 1) ? 8'd0 : 8'($urandom));
      if (ph == 0) begin
        // fill both tables before any tick reads them
        for (int i = 0; i < 256; i++) begin
          pending_items.push_back(mk_write(MODE_ROLL_WR, 8'(i), 8'($urandom)));
          pending_items.push_back(mk_write(MODE_PITCH_WR, 8'(i), 8'($urandom)));
        end
        add_directed();
      end
      add_random(PHASE_ITEMS);
      if (ph == 0) begin
        // pause until the block has emptied, then resume
        wait_drain();
        add_random(PHASE_ITEMS);
      end
      if (ph == 2) begin
        hold_arm = 1'b1;
      end
      wait_drain();
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("gimbal_sine_commutation_drive_core_test: PASS");
    end else begin
      $display("gimbal_sine_commutation_drive_core_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/gscd_pkg.sv
rtl/core/gscd_ram.sv
rtl/core/gscd_scale.sv
rtl/core/gscd_drive_sel.sv
rtl/core/gimbal_sine_commutation_drive_core.sv
rtl/core/gscd_checker.sv
tb/sv/gimbal_sine_commutation_drive_core_test.sv
